// ===== src/srg_pkg.sv =====
// Shared constants and types for the replay guard.
`default_nettype none
package srg_pkg;

  localparam int unsigned CACHE_ENTRIES = 32;

  localparam int unsigned NONCE_HI_W = 32;
  localparam int unsigned NONCE_LO_W = 64;
  localparam int unsigned NONCE_W    = NONCE_HI_W + NONCE_LO_W;

  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned COUNT_W  = 32;

  localparam logic [9:0] MIN_HEADER_LEN = 10'd18;
  localparam logic [7:0] DATA_MSG_TYPE  = 8'd3;

  localparam logic [CFG_W-1:0] EXPECTED_CT_LEN_RST = 16'd768;
  localparam logic [CFG_W-1:0] MAX_TEXT_LEN_RST    = 16'd64;

  // operations
  localparam logic OP_CHECK  = 1'b0;
  localparam logic OP_COMMIT = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_CT_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TEXT_LEN    = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_SHORT = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_TYPE  = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_BAD_CT    = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_TEXT_LONG = 3'd4;
  localparam logic [STATUS_W-1:0] STATUS_REPLAY    = 3'd5;

  // one cache entry as it moves along the chain
  typedef struct packed {
    logic               vld;
    logic [NONCE_W-1:0] nonce;
  } entry_t;

  // chain control: shift moves every entry one cell on,
  // load feeds a new nonce into the first cell instead of the wrapped head
  typedef struct packed {
    logic shift;
    logic load;
  } chain_ctrl_t;

endpackage
`default_nettype wire

// ===== src/srg_cell.sv =====
// One cache cell: holds a nonce and its valid bit, takes the neighbor's on shift.
`default_nettype none
module srg_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  srg_pkg::entry_t entry_i,
  output srg_pkg::entry_t entry_o
);
  import srg_pkg::*;

  logic               vld_q;
  logic               vld_d;
  logic [NONCE_W-1:0] nonce_q;
  logic [NONCE_W-1:0] nonce_d;

  assign vld_d   = shift_i ? entry_i.vld   : vld_q;
  assign nonce_d = shift_i ? entry_i.nonce : nonce_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nonce_q <= nonce_d;
  end

  assign entry_o.vld   = vld_q;
  assign entry_o.nonce = nonce_q;

endmodule
`default_nettype wire

// ===== src/srg_chain.sv =====
// Ring of cache cells with a nonce compare at the head cell.
`default_nettype none
module srg_chain #(
  parameter int unsigned CacheEntries = srg_pkg::CACHE_ENTRIES
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  srg_pkg::chain_ctrl_t         ctrl_i,
  input  logic [srg_pkg::NONCE_W-1:0]  new_nonce_i,
  input  logic [srg_pkg::NONCE_W-1:0]  query_i,
  output logic                         head_match_o
);
  import srg_pkg::*;

  entry_t cell_in  [CacheEntries];
  entry_t cell_out [CacheEntries];
  entry_t feed;

  // first cell takes a fresh nonce on commit, else the head wraps around
  always_comb begin
    if (ctrl_i.load) begin
      feed.vld   = 1'b1;
      feed.nonce = new_nonce_i;
    end else begin
      feed = cell_out[CacheEntries-1];
    end
  end

  for (genvar i = 0; i < CacheEntries; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign cell_in[i] = feed;
    end else begin : g_next
      assign cell_in[i] = cell_out[i-1];
    end

    srg_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ctrl_i.shift),
      .entry_i (cell_in[i]),
      .entry_o (cell_out[i])
    );
  end

  assign head_match_o = cell_out[CacheEntries-1].vld &&
                        (cell_out[CacheEntries-1].nonce == query_i);

endmodule
`default_nettype wire

// ===== src/secure_message_replay_guard.sv =====
// Top level of the replay guard: header checks, cache walk control, result register.
//
// Input channel (in_valid_i/in_ready_o) takes one word per item: a check or a
// commit. Output channel (out_valid_o/out_ready_i) returns one word per item
// with status_o and replay_total_o. Config is a plain write port
// (cfg_we_i, cfg_idx_i, cfg_data_i), to be written by the user only while idle;
// the block itself has no guard for this. A commit shifts the nonce into the
// cell chain, evicting the oldest entry; its result is registered and shown in
// the cycle after acceptance. A check that fails a header test also answers in
// the cycle after acceptance. A check that passes the header tests walks the
// ring of CacheEntries cells: the ring rotates one cell a cycle past a single
// comparator at the head, then the result state loads the output register once
// the receiver is free; no new item is taken during the walk. Commits and
// rejected checks are taken one per cycle while the receiver keeps up.
// Reset clears the valid bits of all cells, the replay counter, and restores
// the config registers; no clearing pass is needed.
// While the receiver stalls, the result holds in the output register and no
// new item is taken until it has been delivered or is being delivered.
`default_nettype none
module secure_message_replay_guard #(
  parameter int unsigned CacheEntries = srg_pkg::CACHE_ENTRIES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             op_i,
  input  logic [9:0]                       pay_bytes_i,
  input  logic [7:0]                       msg_type_i,
  input  logic [15:0]                      ct_bytes_i,
  input  logic [15:0]                      txt_bytes_i,
  input  logic [srg_pkg::NONCE_HI_W-1:0]   nonce_hi_i,
  input  logic [srg_pkg::NONCE_LO_W-1:0]   nonce_lo_i,

  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [srg_pkg::STATUS_W-1:0]     status_o,
  output logic [srg_pkg::COUNT_W-1:0]      replay_total_o,

  input  logic                             cfg_we_i,
  input  logic [srg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [srg_pkg::CFG_W-1:0]        cfg_data_i
);
  import srg_pkg::*;

  localparam int unsigned CntW    = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(CacheEntries - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WALK   = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                hit_q, hit_d;
  logic [NONCE_W-1:0]  query_q, query_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [COUNT_W-1:0]  replay_q, replay_d;
  logic [CFG_W-1:0]    exp_ct_q, exp_ct_d;
  logic [CFG_W-1:0]    max_text_q, max_text_d;

  logic                out_free;
  logic                accept;
  logic [STATUS_W-1:0] hdr_status;
  logic                head_match;
  chain_ctrl_t         ctrl;
  logic [NONCE_W-1:0]  in_nonce;

  assign in_nonce = {nonce_hi_i, nonce_lo_i};
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept = in_valid_i && in_ready_o;

  // header tests in priority order
  always_comb begin
    if (pay_bytes_i < MIN_HEADER_LEN) begin
      hdr_status = STATUS_TOO_SHORT;
    end else if (msg_type_i != DATA_MSG_TYPE) begin
      hdr_status = STATUS_BAD_TYPE;
    end else if (ct_bytes_i != exp_ct_q) begin
      hdr_status = STATUS_BAD_CT;
    end else if (txt_bytes_i > max_text_q) begin
      hdr_status = STATUS_TEXT_LONG;
    end else begin
      hdr_status = STATUS_OK;
    end
  end

  always_comb begin
    exp_ct_d   = exp_ct_q;
    max_text_d = max_text_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_EXPECTED_CT_LEN: exp_ct_d   = cfg_data_i;
        REG_MAX_TEXT_LEN:    max_text_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    hit_d       = hit_q;
    query_d     = query_q;
    status_d    = status_q;
    replay_d    = replay_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ctrl.shift  = 1'b0;
    ctrl.load   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (op_i == OP_COMMIT) begin
            ctrl.shift  = 1'b1;
            ctrl.load   = 1'b1;
            status_d    = STATUS_OK;
            out_valid_d = 1'b1;
          end else if (hdr_status != STATUS_OK) begin
            status_d    = hdr_status;
            out_valid_d = 1'b1;
          end else begin
            query_d = in_nonce;
            cnt_d   = '0;
            hit_d   = 1'b0;
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        // rotate the ring; after CacheEntries steps every entry passed the head
        ctrl.shift = 1'b1;
        hit_d      = hit_q || head_match;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (hit_q) begin
            status_d = STATUS_REPLAY;
            if (replay_q != '1) begin
              replay_d = replay_q + 1'b1;
            end
          end else begin
            status_d = STATUS_OK;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      replay_q    <= '0;
      exp_ct_q    <= EXPECTED_CT_LEN_RST;
      max_text_q  <= MAX_TEXT_LEN_RST;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      replay_q    <= replay_d;
      exp_ct_q    <= exp_ct_d;
      max_text_q  <= max_text_d;
    end
  end

  always_ff @(posedge clk_i) begin
    query_q  <= query_d;
    status_q <= status_d;
  end

  srg_chain #(
    .CacheEntries (CacheEntries)
  ) u_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .new_nonce_i  (in_nonce),
    .query_i      (query_q),
    .head_match_o (head_match)
  );

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign replay_total_o = replay_q;

endmodule
`default_nettype wire

// ===== src/srg_checker.sv =====
// Port-level assertions for the replay guard, bound to the top level.
`default_nettype none
module srg_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           op_i,
  input logic [9:0]                     pay_bytes_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [srg_pkg::STATUS_W-1:0]   status_o,
  input logic [srg_pkg::COUNT_W-1:0]    replay_total_o
);
  import srg_pkg::*;

  // a result word stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result word dropped or changed while stalled");

  // a commit answers ok in the next cycle
  a_commit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_i == OP_COMMIT)
    |=> out_valid_o && (status_o == STATUS_OK))
    else $error("commit did not answer ok at once");

  // a short check is rejected in the next cycle
  a_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_i == OP_CHECK) && (pay_bytes_i < MIN_HEADER_LEN)
    |=> out_valid_o && (status_o == STATUS_TOO_SHORT))
    else $error("short message not rejected at once");

  // the replay count moves only with a fresh replay result, by one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(replay_total_o)
    |-> out_valid_o && (status_o == STATUS_REPLAY) &&
        (replay_total_o == $past(replay_total_o) + 1'b1))
    else $error("replay count changed without a replay result");

endmodule

bind secure_message_replay_guard srg_checker u_srg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .op_i           (op_i),
  .pay_bytes_i    (pay_bytes_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .replay_total_o (replay_total_o)
);
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the replay guard: header checks, nonce cache and replay count.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned LONG_STALL  = 400;
  localparam int unsigned SETTLE      = 2 * CACHE_ENTRIES + 8;
  localparam int unsigned HIST_DEPTH  = 48;

  typedef struct {
    logic                  op;
    logic [9:0]            pay_bytes;
    logic [7:0]            msg_type;
    logic [15:0]           ct_bytes;
    logic [15:0]           txt_bytes;
    logic [NONCE_HI_W-1:0] nonce_hi;
    logic [NONCE_LO_W-1:0] nonce_lo;
  } msg_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  total;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_ready_o;
  logic                  op_drv = OP_CHECK;
  logic [9:0]            pay_bytes_drv = '0;
  logic [7:0]            msg_type_drv = '0;
  logic [15:0]           ct_bytes_drv = '0;
  logic [15:0]           txt_bytes_drv = '0;
  logic [NONCE_HI_W-1:0] nonce_hi_drv = '0;
  logic [NONCE_LO_W-1:0] nonce_lo_drv = '0;

  logic                  out_valid_o;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic [COUNT_W-1:0]    replay_total_o;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  secure_message_replay_guard u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .op_i           (op_drv),
    .pay_bytes_i    (pay_bytes_drv),
    .msg_type_i     (msg_type_drv),
    .ct_bytes_i     (ct_bytes_drv),
    .txt_bytes_i    (txt_bytes_drv),
    .nonce_hi_i     (nonce_hi_drv),
    .nonce_lo_i     (nonce_lo_drv),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .status_o       (status_o),
    .replay_total_o (replay_total_o),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state: register copies and the nonce cache as the block should hold it
  logic [CFG_W-1:0]   ct_len_cfg = EXPECTED_CT_LEN_RST;
  logic [CFG_W-1:0]   text_max_cfg = MAX_TEXT_LEN_RST;
  logic [NONCE_W-1:0] book_nonce [CACHE_ENTRIES];
  bit                 book_vld [CACHE_ENTRIES];
  int unsigned        book_slot = 0;
  logic [COUNT_W-1:0] replays_seen = '0;

  msg_t         pending_msgs [$];
  verdict_t     verdicts_due [$];
  logic [NONCE_W-1:0] nonce_hist [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          send_hold = 1'b0;
  bit          stall_tog = 1'b0;
  bit          stall_seen = 1'b0;
  int unsigned stall_left = 0;

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned n_commits = 0;
  int unsigned n_checks = 0;
  int unsigned tally [6];
  msg_t        cur_msg;
  verdict_t    want;
  verdict_t    due;

  function automatic verdict_t guard_verdict(msg_t m);
    verdict_t v;
    bit hit;
    hit = 1'b0;
    v.status = STATUS_OK;
    if (m.op == OP_COMMIT) begin
      book_nonce[book_slot] = {m.nonce_hi, m.nonce_lo};
      book_vld[book_slot] = 1'b1;
      book_slot = (book_slot + 1) % CACHE_ENTRIES;
    end else if (m.pay_bytes < MIN_HEADER_LEN) begin
      v.status = STATUS_TOO_SHORT;
    end else if (m.msg_type != DATA_MSG_TYPE) begin
      v.status = STATUS_BAD_TYPE;
    end else if (m.ct_bytes != ct_len_cfg) begin
      v.status = STATUS_BAD_CT;
    end else if (m.txt_bytes > text_max_cfg) begin
      v.status = STATUS_TEXT_LONG;
    end else begin
      for (int i = 0; i < CACHE_ENTRIES; i++)
        if (book_vld[i] && book_nonce[i] == {m.nonce_hi, m.nonce_lo}) hit = 1'b1;
      if (hit) begin
        v.status = STATUS_REPLAY;
        if (replays_seen != '1) replays_seen = replays_seen + 1'b1;
      end
    end
    v.total = replays_seen;
    return v;
  endfunction

  function automatic msg_t mk(logic op, logic [9:0] plen, logic [7:0] mtype,
                              logic [15:0] ct, logic [15:0] tlen, logic [NONCE_W-1:0] n);
    msg_t m;
    m.op = op;
    m.pay_bytes = plen;
    m.msg_type = mtype;
    m.ct_bytes = ct;
    m.txt_bytes = tlen;
    {m.nonce_hi, m.nonce_lo} = n;
    return m;
  endfunction

  // nearly half resident or evicted nonces, some one bit off, the rest fresh
  function automatic logic [NONCE_W-1:0] pick_nonce();
    logic [NONCE_W-1:0] n;
    int unsigned r;
    r = $urandom_range(99);
    if (nonce_hist.size() > 0 && r < 55) begin
      n = nonce_hist[$urandom_range(nonce_hist.size() - 1)];
      if (r >= 45) n[$urandom_range(NONCE_W - 1)] ^= 1'b1;
    end else begin
      n = {$urandom, $urandom, $urandom};
    end
    return n;
  endfunction

  function automatic msg_t make_msg();
    msg_t m;
    int unsigned r;
    r = $urandom_range(99);
    m = mk(OP_CHECK, 10'($urandom_range(1023, MIN_HEADER_LEN)), DATA_MSG_TYPE,
           ct_len_cfg, 16'($urandom_range(text_max_cfg)), pick_nonce());
    if ($urandom_range(9) == 0) m.pay_bytes = MIN_HEADER_LEN;
    if ($urandom_range(9) == 0) m.txt_bytes = text_max_cfg;
    if (r < 35) begin
      m.op = OP_COMMIT;
      m.pay_bytes = 10'($urandom);
      m.msg_type = 8'($urandom);
      m.ct_bytes = 16'($urandom);
      m.txt_bytes = 16'($urandom);
      nonce_hist.push_back({m.nonce_hi, m.nonce_lo});
      if (nonce_hist.size() > HIST_DEPTH) void'(nonce_hist.pop_front());
    end else if (r >= 80) begin
      case ($urandom_range(4))
        0: m.pay_bytes = 10'($urandom_range(MIN_HEADER_LEN - 1));
        1: begin
          m.msg_type = 8'($urandom);
          if (m.msg_type == DATA_MSG_TYPE) m.msg_type = DATA_MSG_TYPE + 8'($urandom_range(1));
        end
        2: case ($urandom_range(2))
          0: m.ct_bytes = ct_len_cfg + 16'd1;
          1: m.ct_bytes = ct_len_cfg - 16'd1;
          default: m.ct_bytes = 16'($urandom);
        endcase
        3: m.txt_bytes = 16'($urandom_range(16'hffff, text_max_cfg));
        default: begin
          m.pay_bytes = 10'($urandom);
          m.msg_type = 8'($urandom);
          m.ct_bytes = 16'($urandom);
          m.txt_bytes = 16'($urandom);
        end
      endcase
    end
    return m;
  endfunction

  // driver: predicts each accepted word, then offers the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        want = guard_verdict(cur_msg);
        verdicts_due.push_back(want);
        tally[want.status]++;
        if (cur_msg.op == OP_COMMIT) n_commits++;
        else n_checks++;
      end
      if (!in_valid || in_ready_o) begin
        if (pending_msgs.size() > 0 && !send_hold &&
            $urandom_range(99) >= send_idle_pct) begin
          cur_msg = pending_msgs.pop_front();
          in_valid <= 1'b1;
          op_drv <= cur_msg.op;
          pay_bytes_drv <= cur_msg.pay_bytes;
          msg_type_drv <= cur_msg.msg_type;
          ct_bytes_drv <= cur_msg.ct_bytes;
          txt_bytes_drv <= cur_msg.txt_bytes;
          nonce_hi_drv <= cur_msg.nonce_hi;
          nonce_lo_drv <= cur_msg.nonce_lo;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted apart from the monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_left <= 0;
    end else if (stall_tog != stall_seen) begin
      stall_seen <= stall_tog;
      stall_left <= LONG_STALL;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // monitor: checks each delivered word against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected word, status %0d total %0d", $time, status_o,
                   replay_total_o);
          errors++;
        end else begin
          due = verdicts_due.pop_front();
          if (status_o !== due.status) begin
            $display("%0t: status expected %0d actual %0d", $time, due.status, status_o);
            errors++;
          end
          if (replay_total_o !== due.total) begin
            $display("%0t: replay_total expected %0d actual %0d", $time, due.total,
                     replay_total_o);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, verdicts_due.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic drain();
    while (pending_msgs.size() > 0 || in_valid || verdicts_due.size() > 0)
      @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic set_regs(input logic [CFG_W-1:0] ct, input logic [CFG_W-1:0] tmax);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= REG_EXPECTED_CT_LEN;
    cfg_data <= ct;
    @(posedge clk_i);
    cfg_idx <= REG_MAX_TEXT_LEN;
    cfg_data <= tmax;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    ct_len_cfg = ct;
    text_max_cfg = tmax;
    @(negedge clk_i);
  endtask

  task automatic fill(input int n);
    for (int i = 0; i < n; i++) pending_msgs.push_back(make_msg());
  endtask

  task automatic run_phase(input int n, input int unsigned snd, input int unsigned rcv,
                           input logic [CFG_W-1:0] ct, input logic [CFG_W-1:0] tmax,
                           input bit squeeze);
    set_regs(ct, tmax);
    send_idle_pct = snd;
    recv_stall_pct = rcv;
    if (squeeze) begin
      // receiver holds off while the sender keeps offering words
      fill(n / 3);
      stall_tog = ~stall_tog;
      @(negedge clk_i);
      while (stall_left != 0) @(negedge clk_i);
      fill(n / 3);
      repeat (200) @(negedge clk_i);
      // sender pauses until every outstanding word has come back
      send_hold = 1'b1;
      while (in_valid || verdicts_due.size() > 0) @(negedge clk_i);
      repeat (10) @(negedge clk_i);
      send_hold = 1'b0;
      fill(n - 2 * (n / 3));
    end else begin
      fill(n);
    end
    drain();
  endtask

  initial begin
    logic [NONCE_W-1:0] na;
    logic [NONCE_W-1:0] ones;
    na = 96'h0123_4567_89ab_cdef_0011_2233;
    ones = '1;
    foreach (tally[i]) tally[i] = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed words at the reset register values
    pending_msgs.push_back(mk(OP_CHECK, 10'd100, DATA_MSG_TYPE, 16'd768, 16'd10, na));
    pending_msgs.push_back(mk(OP_COMMIT, 10'd0, 8'd0, 16'd0, 16'd0, na));
    pending_msgs.push_back(mk(OP_CHECK, 10'd100, DATA_MSG_TYPE, 16'd768, 16'd10, na));
    pending_msgs.push_back(mk(OP_CHECK, 10'd17, DATA_MSG_TYPE, 16'd768, 16'd10, na));
    pending_msgs.push_back(mk(OP_CHECK, 10'd0, 8'd255, 16'd0, 16'hffff, na));
    pending_msgs.push_back(mk(OP_CHECK, 10'd18, 8'd2, 16'd768, 16'd10, na));
    pending_msgs.push_back(mk(OP_CHECK, 10'd18, 8'd255, 16'd768, 16'd10, na));
    pending_msgs.push_back(mk(OP_CHECK, 10'd18, DATA_MSG_TYPE, 16'd767, 16'd10, na));
    pending_msgs.push_back(mk(OP_CHECK, 10'd18, DATA_MSG_TYPE, 16'd769, 16'd1000, na));
    pending_msgs.push_back(mk(OP_CHECK, 10'd18, DATA_MSG_TYPE, 16'd768, 16'd65, na));
    pending_msgs.push_back(mk(OP_CHECK, 10'd18, DATA_MSG_TYPE, 16'd768, 16'd64, na));
    pending_msgs.push_back(mk(OP_CHECK, 10'd18, DATA_MSG_TYPE, 16'd768, 16'd0,
                              na ^ 96'd1));
    pending_msgs.push_back(mk(OP_CHECK, 10'd500, DATA_MSG_TYPE, 16'd768, 16'd0,
                              na ^ {1'b1, 95'd0}));
    pending_msgs.push_back(mk(OP_CHECK, 10'd1023, DATA_MSG_TYPE, 16'd768, 16'd64, ones));
    pending_msgs.push_back(mk(OP_COMMIT, 10'h3ff, 8'hff, 16'hffff, 16'hffff, ones));
    pending_msgs.push_back(mk(OP_CHECK, 10'd1023, DATA_MSG_TYPE, 16'd768, 16'd64, ones));
    // duplicate commit stores the nonce a second time
    pending_msgs.push_back(mk(OP_COMMIT, 10'd5, 8'd7, 16'd1, 16'd2, na));
    pending_msgs.push_back(mk(OP_COMMIT, 10'd0, 8'd0, 16'd0, 16'd0, '0));
    pending_msgs.push_back(mk(OP_CHECK, 10'd18, DATA_MSG_TYPE, 16'd768, 16'd1, '0));
    pending_msgs.push_back(mk(OP_CHECK, 10'd18, DATA_MSG_TYPE, 16'd768, 16'd1, na));
    nonce_hist.push_back(na);
    nonce_hist.push_back(ones);
    nonce_hist.push_back('0);
    drain();

    run_phase(400, 0, 0, EXPECTED_CT_LEN_RST, MAX_TEXT_LEN_RST, 1'b1);
    run_phase(400, 76, 0, 16'd0, 16'd0, 1'b0);
    run_phase(400, 0, 76, 16'hffff, 16'hffff, 1'b0);
    run_phase(400, 31, 31, 16'($urandom), 16'($urandom), 1'b0);
    run_phase(300, 0, 0, 16'($urandom_range(1023)), 16'($urandom_range(255)), 1'b0);

    if (verdicts_due.size() != 0) begin
      $display("%0t: %0d predicted words never delivered", $time, verdicts_due.size());
      errors++;
    end
    $display("ran %0d checks and %0d commits over five register settings and four idle mixes",
             n_checks, n_commits);
    $display("status ok %0d short %0d type %0d ct %0d text %0d replay %0d, %0d mismatches",
             tally[STATUS_OK], tally[STATUS_TOO_SHORT], tally[STATUS_BAD_TYPE],
             tally[STATUS_BAD_CT], tally[STATUS_TEXT_LONG], tally[STATUS_REPLAY], errors);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
